### src/bas_pkg.sv
// ----------------------------------------------------------------------------
// bas_pkg: shared types for the bounded array sequence unit
// Request and result payloads, request kinds, status codes and sequencer
// states used by the unit and its port checker.
// ----------------------------------------------------------------------------
`default_nettype none

package bas_pkg;

  // Request kinds; code 7 is unused and answers ok with no change
  typedef enum logic [2:0] {
    KIND_APPEND       = 3'd0,
    KIND_READ_AT      = 3'd1,
    KIND_READ_FIRST   = 3'd2,
    KIND_READ_LAST    = 3'd3,
    KIND_REMOVE_FIRST = 3'd4,
    KIND_REMOVE_LAST  = 3'd5,
    KIND_REMOVE_AT    = 3'd6
  } kind_t;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

  // Sequencer states
  typedef enum logic [1:0] {
    S_IDLE  = 2'd0,
    S_EXEC  = 2'd1,
    S_READ  = 2'd2,
    S_SHIFT = 2'd3
  } state_t;

  // Capacity register value after reset
  localparam logic [6:0] CAP_RESET = 7'd64;

  typedef struct packed {
    logic [2:0]  kind;
    logic [5:0]  position;
    logic [31:0] new_value;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] read_value;
    logic [6:0]  count;
    logic        is_empty;
    logic        is_full;
  } result_t;

endpackage

`default_nettype wire

### src/bas_ram.sv
// ----------------------------------------------------------------------------
// bas_ram: entry storage
// Single write port, single read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module bas_ram #(
  parameter int DEPTH     = 64,
  parameter int WORD_BITS = 32,
  parameter int AW        = 6
) (
  input  wire logic                 clk,
  input  wire logic                 we,
  input  wire logic [AW-1:0]        waddr,
  input  wire logic [WORD_BITS-1:0] wdata,
  input  wire logic [AW-1:0]        raddr,
  output logic      [WORD_BITS-1:0] rdata
);

  logic [WORD_BITS-1:0] mem [DEPTH];

  // Write one entry, read one entry per cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### src/bounded_array_sequence_unit.sv
// ----------------------------------------------------------------------------
// bounded_array_sequence_unit: fixed-capacity ordered list of words
// Appends, indexed and end reads, and removals with shift-down compaction.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel: drive req and raise start; the request transfers at a
//   clock edge where start is high and busy is low. busy stays high until
//   the result is issued.
//   Result channel: done pulses for one cycle with result; the receiver
//   takes it in that cycle and cannot stall it.
//   Config: cfg_we writes cfg_wdata into the capacity register; write only
//   while idle. The active limit is min(capacity, DEPTH).
// Sequencing:
//   Append, remove last, rejected requests: finish in S_EXEC; done is registered.
//   Reads: S_EXEC, then S_READ (one registered read of the entry memory).
//   Remove first / remove at: S_EXEC, then S_SHIFT, in which the entry
//   memory's single read and write ports move one entry per cycle.
//   A new request may transfer in the cycle done is high.
// Reset: rst clears the count, the sequencer and sets capacity to 64;
//   entry contents are left as they were.
// ----------------------------------------------------------------------------
`default_nettype none

module bounded_array_sequence_unit #(
  parameter int DEPTH     = 64,
  parameter int WORD_BITS = 32
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  output logic                  busy,
  input  wire bas_pkg::req_t    req,
  output logic                  done,
  output bas_pkg::result_t      result,
  input  wire logic             cfg_we,
  input  wire logic [6:0]       cfg_wdata
);

  import bas_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int XW = (CW > 7) ? CW : 7;

  state_t               state, state_next;
  kind_t                kind_q;
  logic [5:0]           pos_q;
  logic [WORD_BITS-1:0] val_q;
  logic [CW-1:0]        held, held_next;
  logic [6:0]           capacity;
  logic [CW-1:0]        cursor, cursor_next;
  logic                 pend, pend_next;
  logic [AW-1:0]        wr_addr, wr_addr_next;
  logic                 finish;
  result_t              result_next;

  logic                 we;
  logic [AW-1:0]        waddr, raddr;
  logic [WORD_BITS-1:0] wdata, rdata;

  logic [XW-1:0]        held_x, hn_x, pos_x, cap_x;
  logic [CW-1:0]        held_m1;
  logic                 held_z, pos_ge, full_now, full_next, more;
  status_t              ex_status, res_status;
  logic                 ex_reject;

  // Entry storage
  bas_ram #(
    .DEPTH     (DEPTH),
    .WORD_BITS (WORD_BITS),
    .AW        (AW)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Common compares
  assign held_x    = XW'(held);
  assign hn_x      = XW'(held_next);
  assign pos_x     = XW'(pos_q);
  assign cap_x     = XW'(capacity);
  assign held_m1   = held - 1'b1;
  assign held_z    = (held == '0);
  assign pos_ge    = (pos_x >= held_x);
  assign full_now  = (held_x >= cap_x) || (held_x >= XW'(DEPTH));
  assign full_next = (hn_x >= cap_x) || (hn_x >= XW'(DEPTH));
  assign more      = (cursor < held);
  assign busy      = (state != S_IDLE);

  // Decode the request against the current count
  always_comb begin
    ex_status = ST_OK;
    unique case (kind_q) inside
      KIND_APPEND: begin
        if (full_now) ex_status = ST_FULL;
      end
      KIND_READ_AT: begin
        if (pos_ge) ex_status = ST_RANGE;
      end
      KIND_READ_FIRST, KIND_READ_LAST, KIND_REMOVE_FIRST, KIND_REMOVE_LAST: begin
        if (held_z) ex_status = ST_EMPTY;
      end
      KIND_REMOVE_AT: begin
        if (held_z) ex_status = ST_EMPTY;
        else if (pos_ge) ex_status = ST_RANGE;
      end
      default: ;
    endcase
  end
  assign ex_reject = (ex_status != ST_OK);

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (start) state_next = S_EXEC;
      end
      S_EXEC: begin
        if (ex_reject) begin
          state_next = S_IDLE;
        end else begin
          unique case (kind_q) inside
            KIND_READ_AT, KIND_READ_FIRST, KIND_READ_LAST: state_next = S_READ;
            KIND_REMOVE_FIRST, KIND_REMOVE_AT:             state_next = S_SHIFT;
            default:                                       state_next = S_IDLE;
          endcase
        end
      end
      S_READ: state_next = S_IDLE;
      S_SHIFT: begin
        if (!more && !pend) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Datapath control and memory ports
  always_comb begin
    held_next    = held;
    cursor_next  = cursor;
    pend_next    = pend;
    wr_addr_next = wr_addr;
    we           = 1'b0;
    waddr        = wr_addr;
    wdata        = rdata;
    raddr        = '0;
    finish       = 1'b0;
    res_status   = ST_OK;
    unique case (state)
      S_IDLE: ;
      S_EXEC: begin
        res_status = ex_status;
        if (ex_reject) begin
          finish = 1'b1;
        end else begin
          unique case (kind_q) inside
            KIND_APPEND: begin
              we        = 1'b1;
              waddr     = held[AW-1:0];
              wdata     = val_q;
              held_next = held + 1'b1;
              finish    = 1'b1;
            end
            KIND_READ_AT:    raddr = pos_x[AW-1:0];
            KIND_READ_FIRST: raddr = '0;
            KIND_READ_LAST:  raddr = held_m1[AW-1:0];
            KIND_REMOVE_FIRST: begin
              cursor_next = CW'(1);
              pend_next   = 1'b0;
            end
            KIND_REMOVE_AT: begin
              cursor_next = CW'(pos_x + 1'b1);
              pend_next   = 1'b0;
            end
            KIND_REMOVE_LAST: begin
              held_next = held_m1;
              finish    = 1'b1;
            end
            default: finish = 1'b1;
          endcase
        end
      end
      S_READ: finish = 1'b1;
      S_SHIFT: begin
        // Read the next entry up while writing the previous one down
        if (more) begin
          raddr        = cursor[AW-1:0];
          cursor_next  = cursor + 1'b1;
          wr_addr_next = cursor[AW-1:0] - 1'b1;
          pend_next    = 1'b1;
        end else begin
          pend_next = 1'b0;
        end
        if (pend) begin
          we    = 1'b1;
          waddr = wr_addr;
          wdata = rdata;
        end
        if (!more && !pend) begin
          held_next = held_m1;
          finish    = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // Result fields
  always_comb begin
    result_next.status     = res_status;
    result_next.read_value = (state == S_READ) ? 32'(rdata) : 32'd0;
    result_next.count      = hn_x[6:0];
    result_next.is_empty   = (held_next == '0);
    result_next.is_full    = full_next;
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      held     <= '0;
      capacity <= CAP_RESET;
      cursor   <= '0;
      pend     <= 1'b0;
      done     <= 1'b0;
    end else begin
      state  <= state_next;
      held   <= held_next;
      cursor <= cursor_next;
      pend   <= pend_next;
      done   <= finish;
      if (cfg_we) begin
        capacity <= cfg_wdata;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (start && !busy) begin
      kind_q <= kind_t'(req.kind);
      pos_q  <= req.position;
      val_q  <= WORD_BITS'(req.new_value);
    end
    wr_addr <= wr_addr_next;
    if (finish) begin
      result <= result_next;
    end
  end

endmodule

`default_nettype wire

### src/bas_checker.sv
// ----------------------------------------------------------------------------
// bas_checker: port-level checks for the bounded array sequence unit
// Watches the request, result and busy ports over time.
// ----------------------------------------------------------------------------
`default_nettype none

module bas_checker (
  input wire logic             clk,
  input wire logic             rst,
  input wire logic             start,
  input wire logic             busy,
  input wire logic             done,
  input wire bas_pkg::result_t result
);

  import bas_pkg::*;

  // A transfer makes the unit busy in the next cycle
  a_busy_after_transfer: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("busy low after request transfer");

  // A result only follows a cycle of work
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result issued without a request in progress");

  // Results are single-cycle pulses
  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe held for two cycles");

  // A rejected append leaves the list full
  a_full_flag: assert property (@(posedge clk) disable iff (rst)
    (done && result.status == ST_FULL) |-> result.is_full)
    else $error("full status without full flag");

  // Only a successful request returns a nonzero word
  a_read_ok: assert property (@(posedge clk) disable iff (rst)
    (done && result.read_value != 32'd0) |-> (result.status == ST_OK))
    else $error("nonzero read value on a rejected request");

endmodule

bind bounded_array_sequence_unit bas_checker u_bas_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .done   (done),
  .result (result)
);

`default_nettype wire
